FILE: rtl/core/nsqrt_pkg.sv
// Package for the Newton-Raphson square root block.
// Holds the fixed-point widths, derived counter widths and the sequencer state type.
// No dependencies.
package nsqrt_pkg;

    localparam int WORD_W         = 32;
    localparam int FRACTION_BITS  = 16;
    localparam int MAX_ITERATIONS = 32;
    localparam int COUNT_IN_W     = 6;

    localparam int DIV_W  = WORD_W + FRACTION_BITS;
    localparam int STEP_W = $clog2(DIV_W);
    localparam int ITER_W = $clog2(MAX_ITERATIONS + 1);
    localparam int CNT_W  = (ITER_W > COUNT_IN_W) ? ITER_W : COUNT_IN_W;

    localparam logic [WORD_W-1:0] FIXED_ONE  = WORD_W'(1) << FRACTION_BITS;
    localparam logic [WORD_W-1:0] FIXED_ZERO = '0;
    localparam logic [WORD_W-1:0] WORD_ONES  = '1;

    localparam int IN_BITS  = WORD_W + COUNT_IN_W;
    localparam int IN_PAD_W = ((IN_BITS + 7) / 8) * 8;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_UPDATE,
        ST_DONE
    } nsqrt_state_t;

endpackage

FILE: rtl/core/newton_square_root_top.sv
// Top level of the Newton-Raphson square root block (unsigned Q16.16).
// Bit-serial restoring divider plus one adder for the guess update.
// Depends on nsqrt_pkg.

// One request in, one root out. A request with a zero radicand or a zero count
// skips the iterations and goes straight to the done state. Otherwise each Newton step
// runs the bit-serial restoring divider (one quotient bit per cycle over
// radicand << 16) and then the guess update, for min(iteration_count, 32) steps.
// One request is worked at a time; the result register lets the next request start
// while a result waits.
module newton_square_root_top
    import nsqrt_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [IN_PAD_W-1:0] s_tdata,   // radicand[31:0], iteration_count[37:32], zero pad
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [WORD_W-1:0]   m_tdata    // root[31:0]
);

    nsqrt_state_t state_reg, state_next;

    logic [WORD_W-1:0] x_reg, x_next;
    logic [WORD_W-1:0] z_reg, z_next;
    logic [CNT_W-1:0]  iter_reg, iter_next;
    logic [WORD_W-1:0] rem_reg, rem_next;
    logic [DIV_W-1:0]  dvd_reg, dvd_next;
    logic [WORD_W-1:0] quot_reg, quot_next;
    logic              ovf_reg, ovf_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [WORD_W-1:0] out_data_reg, out_data_next;
    logic              out_valid_reg, out_valid_next;

    logic [WORD_W-1:0] in_radicand;
    logic [CNT_W-1:0]  in_count;
    logic [CNT_W-1:0]  in_count_sat;
    logic              accept;
    logic              last_step;
    logic              out_free;

    logic [WORD_W:0]   shifted;
    logic [WORD_W+1:0] diff;
    logic              qbit;
    logic [WORD_W-1:0] q_sat;
    logic [WORD_W:0]   sum;

    logic              load_req;
    logic              start_div;
    logic              do_div;
    logic              do_update;
    logic              load_out;

    assign in_radicand  = s_tdata[WORD_W-1:0];
    assign in_count     = CNT_W'(s_tdata[WORD_W +: COUNT_IN_W]);
    assign in_count_sat = (in_count > CNT_W'(MAX_ITERATIONS)) ? CNT_W'(MAX_ITERATIONS)
                                                              : in_count;
    assign accept    = s_tvalid && s_tready;
    assign last_step = (step_reg == STEP_W'(DIV_W - 1));
    assign out_free  = !out_valid_reg || m_tready;

    // restoring divide step
    assign shifted = {rem_reg, dvd_reg[DIV_W-1]};
    assign diff    = {1'b0, shifted} - {2'b00, z_reg};
    assign qbit    = !diff[WORD_W+1];
    assign q_sat   = ovf_reg ? WORD_ONES : quot_reg;
    assign sum     = {1'b0, z_reg} + {1'b0, q_sat};

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if ((in_radicand == FIXED_ZERO) || (in_count_sat == '0))
                        state_next = ST_DONE;
                    else
                        state_next = ST_DIVIDE;
                end
            end
            ST_DIVIDE:
            begin
                if (last_step)
                    state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                if (iter_reg == CNT_W'(1))
                    state_next = ST_DONE;
                else
                    state_next = ST_DIVIDE;
            end
            ST_DONE:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // control outputs
    always_comb
    begin
        s_tready  = 1'b0;
        load_req  = 1'b0;
        start_div = 1'b0;
        do_div    = 1'b0;
        do_update = 1'b0;
        load_out  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready  = 1'b1;
                load_req  = accept;
                start_div = accept;
            end
            ST_DIVIDE:
                do_div = 1'b1;
            ST_UPDATE:
            begin
                do_update = 1'b1;
                start_div = 1'b1;
            end
            ST_DONE:
                load_out = out_free;
            default:
                s_tready = 1'b0;
        endcase
    end

    // datapath
    always_comb
    begin
        x_next         = x_reg;
        z_next         = z_reg;
        iter_next      = iter_reg;
        rem_next       = rem_reg;
        dvd_next       = dvd_reg;
        quot_next      = quot_reg;
        ovf_next       = ovf_reg;
        step_next      = step_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg;

        if (load_req)
        begin
            x_next    = in_radicand;
            iter_next = in_count_sat;
            z_next    = (in_radicand == FIXED_ZERO) ? FIXED_ZERO : FIXED_ONE;
        end

        if (do_update)
        begin
            z_next    = sum[WORD_W:1];
            iter_next = iter_reg - CNT_W'(1);
        end

        if (start_div)
        begin
            dvd_next  = {(load_req ? in_radicand : x_reg), {FRACTION_BITS{1'b0}}};
            rem_next  = '0;
            quot_next = '0;
            ovf_next  = 1'b0;
            step_next = '0;
        end
        else if (do_div)
        begin
            dvd_next  = {dvd_reg[DIV_W-2:0], 1'b0};
            rem_next  = qbit ? diff[WORD_W-1:0] : shifted[WORD_W-1:0];
            quot_next = {quot_reg[WORD_W-2:0], qbit};
            ovf_next  = ovf_reg | quot_reg[WORD_W-1];
            step_next = step_reg + STEP_W'(1);
        end

        if (load_out)
        begin
            out_data_next  = z_reg;
            out_valid_next = 1'b1;
        end
        else if (m_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            iter_reg      <= '0;
            step_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            iter_reg      <= iter_next;
            step_reg      <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg        <= x_next;
        z_reg        <= z_next;
        rem_reg      <= rem_next;
        dvd_reg      <= dvd_next;
        quot_reg     <= quot_next;
        ovf_reg      <= ovf_next;
        out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    a_zero_radicand: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (in_radicand == FIXED_ZERO)) |=>
            ((state_reg == ST_DONE) && (z_reg == FIXED_ZERO)))
        else $error("zero radicand did not answer zero");

    a_zero_count: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (in_radicand != FIXED_ZERO) && (in_count_sat == '0)) |=>
            ((state_reg == ST_DONE) && (z_reg == FIXED_ONE)))
        else $error("zero count did not answer the first guess");

    a_iter_live: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_DIVIDE) || (state_reg == ST_UPDATE)) |->
            ((iter_reg != '0) && (iter_reg <= CNT_W'(MAX_ITERATIONS))))
        else $error("step counter out of range while iterating");

endmodule

FILE: tb/sv/tb.sv
// Testbench for newton_square_root_top: streams radicand/count requests with random gaps
// and back-pressure, predicts each root in fixed point and checks the results in order.
// Depends on nsqrt_pkg and newton_square_root_top.
`timescale 1ns / 100ps

module tb;
    import nsqrt_pkg::*;

    localparam int STALL_LIMIT  = 8000;
    localparam int DRAIN_CYCLES = 64;
    localparam int RANDOM_REQS  = 520;

    class root_scoreboard;
        logic [WORD_W-1:0] expected_roots[$];
        int                error_count;
        int                roots_checked;
        int                saturated_reqs;

        function automatic logic [WORD_W-1:0] newton_root(logic [WORD_W-1:0] x,
                                                          logic [COUNT_IN_W-1:0] cnt);
            logic [63:0]       quot;
            logic [WORD_W:0]   total;
            logic [WORD_W-1:0] guess;
            int                steps;
            int                k;
            steps = (cnt > MAX_ITERATIONS) ? MAX_ITERATIONS : int'(cnt);
            if (x == FIXED_ZERO)
                return FIXED_ZERO;
            guess = FIXED_ONE;
            for (k = 0; k < steps; k++)
            begin
                if (guess == FIXED_ZERO)
                    quot = 64'(WORD_ONES);
                else
                begin
                    quot = (64'(x) << FRACTION_BITS) / 64'(guess);
                    if (quot > 64'(WORD_ONES))
                        quot = 64'(WORD_ONES);
                end
                total = {1'b0, guess} + {1'b0, quot[WORD_W-1:0]};
                guess = total[WORD_W:1];
            end
            return guess;
        endfunction

        function void note_request(logic [WORD_W-1:0] x, logic [COUNT_IN_W-1:0] cnt);
            if (cnt > MAX_ITERATIONS)
                saturated_reqs++;
            expected_roots.push_back(newton_root(x, cnt));
        endfunction

        task report_mismatch(string what);
            error_count++;
            $display("[%0t] MISMATCH: %s", $realtime, what);
        endtask

        task check_root(logic [WORD_W-1:0] got);
            logic [WORD_W-1:0] want;
            if (expected_roots.size() == 0)
                report_mismatch($sformatf("unexpected root 0x%08h", got));
            else
            begin
                want = expected_roots.pop_front();
                roots_checked++;
                if (got !== want)
                    report_mismatch($sformatf("root 0x%08h, expected 0x%08h", got, want));
            end
        endtask
    endclass

    logic                clk      = 1'b0;
    logic                rst_n    = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [IN_PAD_W-1:0] s_tdata  = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [WORD_W-1:0]   m_tdata;

    root_scoreboard sb;
    bit             calm;
    int             idle_cycles;
    int             requests_sent;

    newton_square_root_top u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #5 clk = ~clk;

    // mostly short gaps, a few long ones; none during calm stretches
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 15);
        return $urandom_range(20, 60);
    endfunction

    task automatic send_request(input logic [WORD_W-1:0] x, input logic [COUNT_IN_W-1:0] cnt);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(IN_PAD_W - IN_BITS){1'b0}}, cnt, x};
        do @(posedge clk); while (!s_tready);
        requests_sent++;
    endtask

    // request/result monitor and stall watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                sb.note_request(s_tdata[WORD_W-1:0], s_tdata[IN_BITS-1:WORD_W]);
            if (m_tvalid && m_tready)
                sb.check_root(m_tdata);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("Timeout: no transfer for %0d cycles", STALL_LIMIT);
                $display("Some tests failed");
                $finish;
            end
        end
    end

    initial
    begin
        int gap;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            gap = pick_gap();
            if (gap > 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
    end

    initial
    begin
        int                    sel;
        int                    i;
        logic [WORD_W-1:0]     x;
        logic [COUNT_IN_W-1:0] cnt;

        sb = new();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // zero radicand, zero count, extremes, saturation
        send_request(32'h0000_0000, 6'd0);
        send_request(32'h0000_0000, 6'd63);
        send_request(32'h0000_0000, 6'd5);
        send_request(32'hFFFF_FFFF, 6'd0);
        send_request(32'h0001_0000, 6'd0);
        send_request(32'h0000_0001, 6'd1);
        send_request(32'h0000_0001, 6'd32);
        send_request(32'hFFFF_FFFF, 6'd1);
        send_request(32'hFFFF_FFFF, 6'd32);
        send_request(32'hFFFF_FFFF, 6'd63);
        send_request(32'h0001_0000, 6'd1);
        send_request(32'h0004_0000, 6'd10);
        send_request(32'h0002_0000, 6'd20);
        send_request(32'h8000_0000, 6'd33);
        send_request(32'h7FFF_FFFF, 6'd40);
        send_request(32'h0000_FFFF, 6'd6);
        send_request(32'h0009_0000, 6'd31);
        send_request(32'h1234_5678, 6'd16);
        send_request(32'hAAAA_AAAA, 6'd31);
        send_request(32'h5555_5555, 6'd62);

        for (i = 0; i < RANDOM_REQS; i++)
        begin
            calm = (i % 128) >= 96;
            sel = $urandom_range(0, 99);
            if (sel < 5)
                x = '0;
            else if (sel < 15)
                x = $urandom_range(1, 32'h0000_FFFF);
            else if (sel < 25)
                x = 32'hFFFF_0000 | $urandom_range(0, 32'h0000_FFFF);
            else if (sel < 30)
                x = 32'd1 << $urandom_range(0, 31);
            else
                x = $urandom;
            // small counts dominate to keep the run short
            sel = $urandom_range(0, 99);
            if (sel < 5)
                cnt = '0;
            else if (sel < 65)
                cnt = COUNT_IN_W'($urandom_range(1, 8));
            else if (sel < 85)
                cnt = COUNT_IN_W'($urandom_range(9, 31));
            else if (sel < 95)
                cnt = 6'(MAX_ITERATIONS);
            else
                cnt = COUNT_IN_W'($urandom_range(MAX_ITERATIONS + 1, 63));
            send_request(x, cnt);
        end
        calm = 1'b0;
        s_tvalid <= 1'b0;

        while (sb.expected_roots.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d requests (20 directed), %0d roots checked",
                 requests_sent, sb.roots_checked);
        $display("%0d requests had a saturated count; mismatches: %0d",
                 sb.saturated_reqs, sb.error_count);
        if (sb.error_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/core/nsqrt_pkg.sv
rtl/core/newton_square_root_top.sv
tb/sv/tb.sv
